FILE: hdl/dtgc_pkg.sv
// Shared types and constants for the DRAM timing gap checker.
`timescale 1ns / 1ps

package dtgc_pkg;

  // Depth of the per-rank activate history used by the four-activate window.
  localparam int FAW_DEPTH = 4;
  // Width of the per-rank activate count; it saturates at FAW_DEPTH.
  localparam int CNT_W = $clog2(FAW_DEPTH + 1);

  // Configuration port widths.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Command types carried in the func field.
  typedef enum logic [3:0] {
    FUNC_ACT    = 4'd0,
    FUNC_RD     = 4'd1,
    FUNC_RDAP   = 4'd2,
    FUNC_WR     = 4'd3,
    FUNC_WRAP   = 4'd4,
    FUNC_PRE    = 4'd5,
    FUNC_REFALL = 4'd6
  } func_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_T_RP    = 3'd0,
    CFG_T_RRD   = 3'd1,
    CFG_T_RC    = 3'd2,
    CFG_T_FAW   = 3'd3,
    CFG_T_RFC   = 3'd4,
    CFG_T_RAS   = 3'd5,
    CFG_CAS     = 3'd6,
    CFG_OTHER   = 3'd7
  } cfg_idx_e;

  // Timing configuration. The packed registers hold bytes, low byte first:
  // cas_timings is tRCD, tCAS, tCWD, tBurst; other_timings is tWTR, tRTRS,
  // tRTP, tCMD, tWR, tAL.
  typedef struct packed {
    logic [7:0]  t_rp;
    logic [7:0]  t_rrd;
    logic [7:0]  t_rc;
    logic [7:0]  t_faw;
    logic [9:0]  t_rfc;
    logic [7:0]  t_ras;
    logic [31:0] cas_timings;
    logic [47:0] other_timings;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    t_rp:          8'd4,
    t_rrd:         8'd3,
    t_rc:          8'd16,
    t_faw:         8'd14,
    t_rfc:         10'd50,
    t_ras:         8'd12,
    cas_timings:   32'd0,
    other_timings: 48'd0
  };

  // Timestamp write enables for the per-bank memories.
  typedef struct packed {
    logic act;
    logic pre;
    logic rd;
    logic wr;
  } bank_we_t;

  // Timestamp write enables for the per-rank registers.
  typedef struct packed {
    logic act;
    logic rd;
    logic wr;
    logic pre;
    logic refr;
  } rank_we_t;

endpackage

FILE: hdl/dtgc_ram.sv
// Generic single-port-write, single-port-read RAM with registered, write-first read.
`timescale 1ns / 1ps

module dtgc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; a write to the same address in the same cycle is passed through.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      if (we_i && (waddr_i == raddr_i)) begin
        rdata_q <= wdata_i;
      end else begin
        rdata_q <= mem_q[raddr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dtgc_bank_state.sv
// Per-bank timestamp memories (activate, precharge, read, write) with valid bits.
`timescale 1ns / 1ps

module dtgc_bank_state #(
  parameter int DEPTH     = 32,
  parameter int TIME_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  input  dtgc_pkg::bank_we_t                        we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [TIME_BITS-1:0]                      wr_time_i,
  output logic [TIME_BITS-1:0]                      act_time_o,
  output logic [TIME_BITS-1:0]                      pre_time_o,
  output logic [TIME_BITS-1:0]                      read_time_o,
  output logic [TIME_BITS-1:0]                      write_time_o
);

  localparam int NMEM = 4;

  logic [NMEM-1:0]      we_vec;
  logic [TIME_BITS-1:0] rdata   [NMEM];
  logic [TIME_BITS-1:0] time_rd [NMEM];
  logic [DEPTH-1:0]     vld_q   [NMEM];
  logic [NMEM-1:0]      vld_rd_q;

  assign we_vec = {we_i.wr, we_i.rd, we_i.pre, we_i.act};

  // One memory per timestamp kind; an entry never written reads as zero.
  for (genvar k = 0; k < NMEM; k++) begin : g_mem
    dtgc_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we_vec[k]),
      .waddr_i (wr_addr_i),
      .wdata_i (wr_time_i),
      .re_i    (rd_en_i),
      .raddr_i (rd_addr_i),
      .rdata_o (rdata[k])
    );

    // Valid bits cleared by reset, read alongside the memory.
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k]    <= '0;
        vld_rd_q[k] <= 1'b0;
      end else begin
        if (we_vec[k]) begin
          vld_q[k][wr_addr_i] <= 1'b1;
        end
        if (rd_en_i) begin
          vld_rd_q[k] <= vld_q[k][rd_addr_i] | (we_vec[k] && (wr_addr_i == rd_addr_i));
        end
      end
    end

    assign time_rd[k] = vld_rd_q[k] ? rdata[k] : '0;
  end

  assign act_time_o   = time_rd[0];
  assign pre_time_o   = time_rd[1];
  assign read_time_o  = time_rd[2];
  assign write_time_o = time_rd[3];

endmodule

FILE: hdl/dtgc_rank_state.sv
// Per-rank timestamp registers and the per-rank activate history.
`timescale 1ns / 1ps

module dtgc_rank_state #(
  parameter int RANKS     = 4,
  parameter int TIME_BITS = 32
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic [((RANKS > 1) ? $clog2(RANKS) : 1)-1:0] rank_i,
  input  dtgc_pkg::rank_we_t                        we_i,
  input  logic [TIME_BITS-1:0]                      wr_time_i,
  output logic [TIME_BITS-1:0]                      read_time_o,
  output logic [TIME_BITS-1:0]                      write_time_o,
  output logic [TIME_BITS-1:0]                      refresh_time_o,
  output logic [TIME_BITS-1:0]                      pre_time_o,
  output logic [TIME_BITS-1:0]                      act_newest_o,
  output logic [TIME_BITS-1:0]                      act_oldest_o,
  output logic                                      act_seen_o,
  output logic                                      act_full_o
);

  localparam int FD = dtgc_pkg::FAW_DEPTH;
  localparam logic [dtgc_pkg::CNT_W-1:0] CNT_MAX = dtgc_pkg::CNT_W'(FD);

  logic [TIME_BITS-1:0]       rd_q   [RANKS];
  logic [TIME_BITS-1:0]       wr_q   [RANKS];
  logic [TIME_BITS-1:0]       ref_q  [RANKS];
  logic [TIME_BITS-1:0]       pre_q  [RANKS];
  logic [TIME_BITS-1:0]       hist_q [RANKS][FD];
  logic [dtgc_pkg::CNT_W-1:0] cnt_q  [RANKS];

  // Timestamp updates for the addressed rank; an activate shifts the history.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < RANKS; r++) begin
        rd_q[r]  <= '0;
        wr_q[r]  <= '0;
        ref_q[r] <= '0;
        pre_q[r] <= '0;
        cnt_q[r] <= '0;
        for (int i = 0; i < FD; i++) begin
          hist_q[r][i] <= '0;
        end
      end
    end else begin
      if (we_i.rd) begin
        rd_q[rank_i] <= wr_time_i;
      end
      if (we_i.wr) begin
        wr_q[rank_i] <= wr_time_i;
      end
      if (we_i.refr) begin
        ref_q[rank_i] <= wr_time_i;
      end
      if (we_i.pre) begin
        pre_q[rank_i] <= wr_time_i;
      end
      if (we_i.act) begin
        for (int i = FD - 1; i > 0; i--) begin
          hist_q[rank_i][i] <= hist_q[rank_i][i-1];
        end
        hist_q[rank_i][0] <= wr_time_i;
        if (cnt_q[rank_i] < CNT_MAX) begin
          cnt_q[rank_i] <= cnt_q[rank_i] + 1'b1;
        end
      end
    end
  end

  // Values seen by the command of the addressed rank.
  assign read_time_o    = rd_q[rank_i];
  assign write_time_o   = wr_q[rank_i];
  assign refresh_time_o = ref_q[rank_i];
  assign pre_time_o     = pre_q[rank_i];
  assign act_newest_o   = hist_q[rank_i][0];
  assign act_oldest_o   = hist_q[rank_i][FD-1];
  assign act_seen_o     = (cnt_q[rank_i] != '0);
  assign act_full_o     = (cnt_q[rank_i] >= CNT_MAX);

endmodule

FILE: hdl/dtgc_gap_calc.sv
// Combinational gap computation: constraint terms, max tree and saturation.
`timescale 1ns / 1ps

module dtgc_gap_calc #(
  parameter int TIME_BITS = 32
) (
  input  logic [3:0]           func_i,
  input  logic                 posted_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  dtgc_pkg::cfg_t       cfg_i,
  input  logic [TIME_BITS-1:0] bank_act_i,
  input  logic [TIME_BITS-1:0] bank_pre_i,
  input  logic [TIME_BITS-1:0] bank_read_i,
  input  logic [TIME_BITS-1:0] bank_write_i,
  input  logic [TIME_BITS-1:0] rank_read_i,
  input  logic [TIME_BITS-1:0] rank_write_i,
  input  logic [TIME_BITS-1:0] rank_refresh_i,
  input  logic [TIME_BITS-1:0] rank_pre_i,
  input  logic [TIME_BITS-1:0] act_newest_i,
  input  logic [TIME_BITS-1:0] act_oldest_i,
  input  logic                 act_seen_i,
  input  logic                 act_full_i,
  output logic signed [31:0]   gap_o
);

  // Working width: the signed time difference plus headroom for the offsets.
  localparam int SW = ((TIME_BITS > 32) ? TIME_BITS : 32) + 2;

  typedef logic signed [SW-1:0] wide_t;

  localparam wide_t MIN_W = {1'b1, {(SW-1){1'b0}}};

  // Signed distance from now to a recorded time, modulo the time width.
  function automatic wide_t since(input logic [TIME_BITS-1:0] last,
                                  input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] d;
    d = last - now;
    return wide_t'({{(SW-TIME_BITS){d[TIME_BITS-1]}}, d});
  endfunction

  function automatic wide_t zx(input logic [9:0] v);
    return wide_t'({{(SW-10){1'b0}}, v});
  endfunction

  function automatic wide_t max2(input wide_t a, input wide_t b);
    return (a > b) ? a : b;
  endfunction

  logic [7:0] trcd, tcas, tcwd, tburst, twtr, trtrs, trtp, tcmd, twr, tal;
  logic [7:0] trtp_eff;
  wide_t      g;
  logic [SW-32:0] hi;

  // Timing fields from the packed registers.
  always_comb begin
    trcd     = cfg_i.cas_timings[7:0];
    tcas     = cfg_i.cas_timings[15:8];
    tcwd     = cfg_i.cas_timings[23:16];
    tburst   = cfg_i.cas_timings[31:24];
    twtr     = cfg_i.other_timings[7:0];
    trtrs    = cfg_i.other_timings[15:8];
    trtp     = cfg_i.other_timings[23:16];
    tcmd     = cfg_i.other_timings[31:24];
    twr      = cfg_i.other_timings[39:32];
    tal      = posted_i ? cfg_i.other_timings[47:40] : 8'd0;
    trtp_eff = (trtp > tcmd) ? (trtp - tcmd) : 8'd0;
  end

  // Largest of the constraint terms that apply to the command type.
  always_comb begin
    case (dtgc_pkg::func_e'(func_i))
      dtgc_pkg::FUNC_ACT: begin
        g = since(bank_pre_i, now_i) + zx({2'b00, cfg_i.t_rp});
        g = max2(g, act_seen_i ?
                 since(act_newest_i, now_i) + zx({2'b00, cfg_i.t_rrd}) : MIN_W);
        g = max2(g, since(bank_act_i, now_i) + zx({2'b00, cfg_i.t_rc}));
        g = max2(g, act_full_i ?
                 since(act_oldest_i, now_i) + zx({2'b00, cfg_i.t_faw}) : MIN_W);
        g = max2(g, since(rank_refresh_i, now_i) + zx(cfg_i.t_rfc));
      end
      dtgc_pkg::FUNC_RD, dtgc_pkg::FUNC_RDAP: begin
        g = since(bank_act_i, now_i) + zx({2'b00, trcd}) - zx({2'b00, tal});
        g = max2(g, since(rank_read_i, now_i) + zx({2'b00, tburst}));
        g = max2(g, since(rank_write_i, now_i) + zx({2'b00, tcwd})
                    + zx({2'b00, tburst}) + zx({2'b00, twtr}));
      end
      dtgc_pkg::FUNC_WR, dtgc_pkg::FUNC_WRAP: begin
        g = since(bank_act_i, now_i) + zx({2'b00, trcd}) - zx({2'b00, tal});
        g = max2(g, since(rank_read_i, now_i) + zx({2'b00, tcas}) + zx({2'b00, tburst})
                    + zx({2'b00, trtrs}) - zx({2'b00, tcwd}));
        g = max2(g, since(rank_write_i, now_i) + zx({2'b00, tburst}));
      end
      dtgc_pkg::FUNC_PRE: begin
        // The activate-to-precharge term is floored at zero, so the result is too.
        g = max2('0, since(bank_act_i, now_i) + zx({2'b00, cfg_i.t_ras}));
        g = max2(g, since(bank_read_i, now_i) + zx({2'b00, tal}) + zx({2'b00, tcas})
                    + zx({2'b00, tburst}) + zx({2'b00, trtp_eff}));
        g = max2(g, since(bank_write_i, now_i) + zx({2'b00, tal}) + zx({2'b00, tcwd})
                    + zx({2'b00, tburst}) + zx({2'b00, twr}));
      end
      dtgc_pkg::FUNC_REFALL: begin
        g = max2(since(rank_refresh_i, now_i) + zx(cfg_i.t_rfc),
                 since(rank_pre_i, now_i) + zx({2'b00, cfg_i.t_rp}));
      end
      default: begin
        g = '0;
      end
    endcase
  end

  // Saturate to the signed 32-bit range.
  assign hi = g[SW-1:31];

  always_comb begin
    if ((&hi) || !(|hi)) begin
      gap_o = g[31:0];
    end else if (g[SW-1]) begin
      gap_o = 32'sh8000_0000;
    end else begin
      gap_o = 32'sh7fff_ffff;
    end
  end

endmodule

FILE: hdl/dram_timing_gap_checker.sv
// Top level of the DRAM timing gap checker: handshakes, configuration and state update.
`timescale 1ns / 1ps

// Channel      | Direction | Handshake                 | Payload
// -------------+-----------+---------------------------+---------------------------------
// command in   | input     | in_valid_i / in_ready_o   | func, rank_id, bank_id,
//              |           |                           | posted_cas, now, issue
// gap out      | output    | out_valid_o / out_ready_i | gap
// config write | input     | cfg_we_i (no wait)        | cfg_index_i, cfg_data_i
//
// One command per cycle is sustained while results are taken. A command is captured in the
// input register at the same edge at which the bank timestamp memories read its entries, and
// its gap is registered when the command leaves the input register. The single compute
// stage between the input register and the result register, together with one memory read
// per cycle, sets the rate. Timestamps of an issued command are written as it leaves the
// compute stage, and the memories pass a same-cycle write through to the next command's read.
// Reset clears the per-entry valid bits at once, so no clearing pass is needed.
// When the result is not taken, the input register holds its command and acceptance stops
// once that register is occupied, so at most two commands wait.

module dram_timing_gap_checker #(
  parameter int RANKS     = 4,
  parameter int BANKS     = 8,
  parameter int TIME_BITS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dtgc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dtgc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [3:0]                      func_i,
  input  logic [1:0]                      rank_id_i,
  input  logic [2:0]                      bank_id_i,
  input  logic                            posted_cas_i,
  input  logic [31:0]                     now_i,
  input  logic                            issue_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              gap_o
);

  localparam int DEPTH = RANKS * BANKS;
  localparam int RW    = (RANKS > 1) ? $clog2(RANKS) : 1;
  localparam int BW    = (BANKS > 1) ? $clog2(BANKS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [3:0] RANKS_W = 4'(RANKS);
  localparam logic [4:0] BANKS_W = 5'(BANKS);

  dtgc_pkg::cfg_t cfg_q;

  logic                 in_vld_q;
  logic [3:0]           func_q;
  logic [RW-1:0]        rank_q;
  logic [AW-1:0]        bank_addr_q;
  logic                 posted_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 issue_q;

  logic                 out_vld_q;
  logic signed [31:0]   gap_q;
  logic signed [31:0]   gap_d;

  logic                 accept;
  logic                 adv;
  logic [3:0]           rank_tmp;
  logic [4:0]           bank_tmp;
  logic [RW-1:0]        rank_red;
  logic [BW-1:0]        bank_red;
  logic [AW-1:0]        bank_addr;

  dtgc_pkg::bank_we_t   bank_we;
  dtgc_pkg::rank_we_t   rank_we;

  logic [TIME_BITS-1:0] b_act, b_pre, b_rd, b_wr;
  logic [TIME_BITS-1:0] r_rd, r_wr, r_ref, r_pre, a_new, a_old;
  logic                 a_seen, a_full;

  // Handshake control.
  assign adv        = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;
  assign accept     = in_valid_i && in_ready_o;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= dtgc_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      case (dtgc_pkg::cfg_idx_e'(cfg_index_i))
        dtgc_pkg::CFG_T_RP:  cfg_q.t_rp          <= cfg_data_i[7:0];
        dtgc_pkg::CFG_T_RRD: cfg_q.t_rrd         <= cfg_data_i[7:0];
        dtgc_pkg::CFG_T_RC:  cfg_q.t_rc          <= cfg_data_i[7:0];
        dtgc_pkg::CFG_T_FAW: cfg_q.t_faw         <= cfg_data_i[7:0];
        dtgc_pkg::CFG_T_RFC: cfg_q.t_rfc         <= cfg_data_i[9:0];
        dtgc_pkg::CFG_T_RAS: cfg_q.t_ras         <= cfg_data_i[7:0];
        dtgc_pkg::CFG_CAS:   cfg_q.cas_timings   <= cfg_data_i[31:0];
        dtgc_pkg::CFG_OTHER: cfg_q.other_timings <= cfg_data_i[47:0];
        default: begin
        end
      endcase
    end
  end

  // Rank and bank wrap into the configured counts by repeated subtraction.
  always_comb begin
    rank_tmp = {2'b00, rank_id_i};
    for (int i = 0; i < 3; i++) begin
      if (rank_tmp >= RANKS_W) begin
        rank_tmp = rank_tmp - RANKS_W;
      end
    end
    bank_tmp = {2'b00, bank_id_i};
    for (int i = 0; i < 7; i++) begin
      if (bank_tmp >= BANKS_W) begin
        bank_tmp = bank_tmp - BANKS_W;
      end
    end
  end

  assign rank_red  = rank_tmp[RW-1:0];
  assign bank_red  = bank_tmp[BW-1:0];
  assign bank_addr = AW'(int'(rank_red) * BANKS + int'(bank_red));

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q      <= func_i;
      rank_q      <= rank_red;
      bank_addr_q <= bank_addr;
      posted_q    <= posted_cas_i;
      now_q       <= TIME_BITS'(now_i);
      issue_q     <= issue_i;
    end
  end

  // Timestamp write enables for an issued command leaving the compute stage.
  always_comb begin
    bank_we = '0;
    rank_we = '0;
    if (adv && issue_q) begin
      case (dtgc_pkg::func_e'(func_q))
        dtgc_pkg::FUNC_ACT: begin
          bank_we.act = 1'b1;
          rank_we.act = 1'b1;
        end
        dtgc_pkg::FUNC_RD, dtgc_pkg::FUNC_RDAP: begin
          bank_we.rd = 1'b1;
          rank_we.rd = 1'b1;
        end
        dtgc_pkg::FUNC_WR, dtgc_pkg::FUNC_WRAP: begin
          bank_we.wr = 1'b1;
          rank_we.wr = 1'b1;
        end
        dtgc_pkg::FUNC_PRE: begin
          bank_we.pre = 1'b1;
          rank_we.pre = 1'b1;
        end
        dtgc_pkg::FUNC_REFALL: begin
          rank_we.refr = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Per-bank timestamps, read as the command is accepted.
  dtgc_bank_state #(
    .DEPTH     (DEPTH),
    .TIME_BITS (TIME_BITS)
  ) u_bank_state (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rd_en_i      (accept),
    .rd_addr_i    (bank_addr),
    .we_i         (bank_we),
    .wr_addr_i    (bank_addr_q),
    .wr_time_i    (now_q),
    .act_time_o   (b_act),
    .pre_time_o   (b_pre),
    .read_time_o  (b_rd),
    .write_time_o (b_wr)
  );

  // Per-rank timestamps and activate history.
  dtgc_rank_state #(
    .RANKS     (RANKS),
    .TIME_BITS (TIME_BITS)
  ) u_rank_state (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .rank_i         (rank_q),
    .we_i           (rank_we),
    .wr_time_i      (now_q),
    .read_time_o    (r_rd),
    .write_time_o   (r_wr),
    .refresh_time_o (r_ref),
    .pre_time_o     (r_pre),
    .act_newest_o   (a_new),
    .act_oldest_o   (a_old),
    .act_seen_o     (a_seen),
    .act_full_o     (a_full)
  );

  // Gap computation.
  dtgc_gap_calc #(
    .TIME_BITS (TIME_BITS)
  ) u_gap_calc (
    .func_i         (func_q),
    .posted_i       (posted_q),
    .now_i          (now_q),
    .cfg_i          (cfg_q),
    .bank_act_i     (b_act),
    .bank_pre_i     (b_pre),
    .bank_read_i    (b_rd),
    .bank_write_i   (b_wr),
    .rank_read_i    (r_rd),
    .rank_write_i   (r_wr),
    .rank_refresh_i (r_ref),
    .rank_pre_i     (r_pre),
    .act_newest_i   (a_new),
    .act_oldest_i   (a_old),
    .act_seen_i     (a_seen),
    .act_full_i     (a_full),
    .gap_o          (gap_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      gap_q <= gap_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign gap_o       = gap_q;

`ifndef SYNTHESIS
  // An accepted transaction always lands in the input register.
  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_vld_q)
    else $error("accepted transaction did not load the input register");

  // A transaction leaving the compute stage shows its gap in the result register.
  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (out_vld_q && (gap_q == $past(gap_d))))
    else $error("result register did not capture the computed gap");

  // A stalled transaction keeps its payload in the input register.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !adv) |=> (in_vld_q && $stable(now_q) && $stable(func_q)
                            && $stable(bank_addr_q)))
    else $error("stalled transaction changed in the input register");

  // Input back-pressure only when both stages are full and the output is stalled.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (in_vld_q && out_vld_q && !out_ready_i))
    else $error("input stalled without a full, blocked pipeline");
`endif

endmodule

FILE: verif/dram_timing_gap_checker_tb.sv
// Self-checking testbench for the DRAM timing gap checker with a built-in gap predictor.
`timescale 1ns / 1ps

import dtgc_pkg::*;

// Predicts the gap for every accepted command and checks returned gaps in order.
class gap_scoreboard;
  cfg_t              timing;
  logic [31:0]       bank_act_ts [32];
  logic [31:0]       bank_pre_ts [32];
  logic [31:0]       bank_rd_ts  [32];
  logic [31:0]       bank_wr_ts  [32];
  logic [31:0]       rank_rd_ts  [4];
  logic [31:0]       rank_wr_ts  [4];
  logic [31:0]       rank_ref_ts [4];
  logic [31:0]       rank_pre_ts [4];
  logic [31:0]       act_hist    [4][4];
  int unsigned       act_count   [4];
  logic signed [31:0] expected_gaps [$];
  int                n_fail;

  function new();
    timing = CFG_RESET;
    foreach (bank_act_ts[i]) begin
      bank_act_ts[i] = '0;
      bank_pre_ts[i] = '0;
      bank_rd_ts[i]  = '0;
      bank_wr_ts[i]  = '0;
    end
    foreach (rank_rd_ts[i]) begin
      rank_rd_ts[i]  = '0;
      rank_wr_ts[i]  = '0;
      rank_ref_ts[i] = '0;
      rank_pre_ts[i] = '0;
      act_count[i]   = 0;
      foreach (act_hist[i][j]) act_hist[i][j] = '0;
    end
    n_fail = 0;
  endfunction

  task report(string msg);
    if (n_fail < 40) $display("ERROR @%0t: %s", $realtime, msg);
    n_fail++;
  endtask

  function int pending();
    return expected_gaps.size();
  endfunction

  // Mirrors a register write; bits beyond the register width are dropped.
  function void write_reg(cfg_idx_e idx, logic [47:0] data);
    case (idx)
      CFG_T_RP:  timing.t_rp          = data[7:0];
      CFG_T_RRD: timing.t_rrd         = data[7:0];
      CFG_T_RC:  timing.t_rc          = data[7:0];
      CFG_T_FAW: timing.t_faw         = data[7:0];
      CFG_T_RFC: timing.t_rfc         = data[9:0];
      CFG_T_RAS: timing.t_ras         = data[7:0];
      CFG_CAS:   timing.cas_timings   = data[31:0];
      CFG_OTHER: timing.other_timings = data;
      default: ;
    endcase
  endfunction

  // Signed distance from the command time to a recorded time, modulo 2^32.
  function longint span(logic [31:0] last, logic [31:0] t);
    int d;
    d = last - t;
    return d;
  endfunction

  function longint larger(longint a, longint b);
    return (a > b) ? a : b;
  endfunction

  // Works out the gap of one accepted command, then records its timestamps.
  function void note_command(logic [3:0] func, logic [1:0] rank, logic [2:0] bank,
                             logic posted, logic [31:0] t, logic issue);
    int     bi;
    longint rp, rrd, rc, faw, rfc, ras;
    longint trcd, tcas, tcwd, tburst, twtr, trtrs, trtp, tcmd, twr, tal;
    longint g, w;
    bi     = {rank, bank};
    rp     = timing.t_rp;
    rrd    = timing.t_rrd;
    rc     = timing.t_rc;
    faw    = timing.t_faw;
    rfc    = timing.t_rfc;
    ras    = timing.t_ras;
    trcd   = timing.cas_timings[7:0];
    tcas   = timing.cas_timings[15:8];
    tcwd   = timing.cas_timings[23:16];
    tburst = timing.cas_timings[31:24];
    twtr   = timing.other_timings[7:0];
    trtrs  = timing.other_timings[15:8];
    trtp   = timing.other_timings[23:16];
    tcmd   = timing.other_timings[31:24];
    twr    = timing.other_timings[39:32];
    tal    = posted ? longint'(timing.other_timings[47:40]) : 0;
    g      = 0;

    case (func)
      FUNC_ACT: begin
        g = span(bank_pre_ts[bi], t) + rp;
        if (act_count[rank] > 0) g = larger(g, span(act_hist[rank][0], t) + rrd);
        g = larger(g, span(bank_act_ts[bi], t) + rc);
        // The four-activate window looks at the oldest of the last four activates.
        if (act_count[rank] >= FAW_DEPTH) g = larger(g, span(act_hist[rank][3], t) + faw);
        g = larger(g, span(rank_ref_ts[rank], t) + rfc);
      end
      FUNC_RD, FUNC_RDAP: begin
        g = span(bank_act_ts[bi], t) + trcd - tal;
        g = larger(g, span(rank_rd_ts[rank], t) + tburst);
        g = larger(g, span(rank_wr_ts[rank], t) + tcwd + tburst + twtr);
      end
      FUNC_WR, FUNC_WRAP: begin
        g = span(bank_act_ts[bi], t) + trcd - tal;
        g = larger(g, span(rank_rd_ts[rank], t) + tcas + tburst + trtrs - tcwd);
        g = larger(g, span(rank_wr_ts[rank], t) + tburst);
      end
      FUNC_PRE: begin
        g = span(bank_act_ts[bi], t) + ras;
        w = larger(0, span(bank_rd_ts[bi], t) + tal + tcas + tburst + larger(0, trtp - tcmd));
        w = larger(w, span(bank_wr_ts[bi], t) + tal + tcwd + tburst + twr);
        g = larger(g, w);
      end
      FUNC_REFALL: begin
        g = larger(span(rank_ref_ts[rank], t) + rfc, span(rank_pre_ts[rank], t) + rp);
      end
      default: g = 0;
    endcase

    if (g > 64'sd2147483647) g = 64'sd2147483647;
    if (g < -64'sd2147483648) g = -64'sd2147483648;
    expected_gaps.push_back(g[31:0]);

    if (issue) begin
      case (func)
        FUNC_ACT: begin
          bank_act_ts[bi] = t;
          for (int i = 3; i > 0; i--) act_hist[rank][i] = act_hist[rank][i-1];
          act_hist[rank][0] = t;
          if (act_count[rank] < FAW_DEPTH) act_count[rank]++;
        end
        FUNC_RD, FUNC_RDAP: begin
          bank_rd_ts[bi]   = t;
          rank_rd_ts[rank] = t;
        end
        FUNC_WR, FUNC_WRAP: begin
          bank_wr_ts[bi]   = t;
          rank_wr_ts[rank] = t;
        end
        FUNC_PRE: begin
          bank_pre_ts[bi]   = t;
          rank_pre_ts[rank] = t;
        end
        FUNC_REFALL: rank_ref_ts[rank] = t;
        default: ;
      endcase
    end
  endfunction

  task check_gap(logic signed [31:0] got);
    logic signed [31:0] want;
    if (expected_gaps.size() == 0) begin
      report($sformatf("gap %0d returned with no command waiting", got));
    end else begin
      want = expected_gaps.pop_front();
      if (got !== want) report($sformatf("gap mismatch: got %0d, expected %0d", got, want));
    end
  endtask
endclass

module dram_timing_gap_checker_tb;

  // Command codes the block treats as no-ops.
  localparam logic [3:0] FUNC_NOP_FIRST = 4'd7;
  localparam logic [3:0] FUNC_NOP_MID   = 4'd12;
  localparam logic [3:0] FUNC_NOP_LAST  = 4'd15;
  localparam int         HOLD_CYCLES    = 300;
  localparam int         ITEMS_PER_SEG  = 235;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [3:0]            func_i;
  logic [1:0]            rank_id_i;
  logic [2:0]            bank_id_i;
  logic                  posted_cas_i;
  logic [31:0]           now_i;
  logic                  issue_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic signed [31:0]    gap_o;

  gap_scoreboard sb;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  bit            hold_req = 1'b0;
  logic [31:0]   cur_time;

  dram_timing_gap_checker DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .func_i       (func_i),
    .rank_id_i    (rank_id_i),
    .bank_id_i    (bank_id_i),
    .posted_cas_i (posted_cas_i),
    .now_i        (now_i),
    .issue_i      (issue_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .gap_o        (gap_o)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watch both channels; values sampled at the edge are the pre-edge values.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (in_valid_i && in_ready_o)
        sb.note_command(func_i, rank_id_i, bank_id_i, posted_cas_i, now_i, issue_i);
      if (out_valid_o && out_ready_i) sb.check_gap(gap_o);
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Writes one timing register and mirrors it in the predictor.
  task automatic program_reg(cfg_idx_e idx, logic [47:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // Loads a full timing set; the set depends on the test segment.
  task automatic program_timings(int seg);
    logic [47:0] vals [8];
    case (seg)
      0: begin
        vals = '{48'd4, 48'd3, 48'd16, 48'd14, 48'd50, 48'd12,
                 48'h0000_0403_0404, 48'h0205_0103_0103};
      end
      1: foreach (vals[i]) vals[i] = '1;
      2: foreach (vals[i]) vals[i] = '0;
      3: foreach (vals[i]) vals[i] = {16'($urandom), 32'($urandom)};
      default: begin
        foreach (vals[i]) begin
          vals[i] = 48'($urandom_range(20));
          if (i >= 6) begin
            for (int k = 0; k < 6; k++) vals[i][8*k +: 8] = 8'($urandom_range(12));
          end
        end
      end
    endcase
    for (int i = 0; i < 8; i++) program_reg(cfg_idx_e'(i), vals[i]);
    cfg_we_i <= 1'b0;
  endtask

  // Offers one command and returns at the edge where it is accepted.
  task automatic send_command(logic [3:0] f, logic [1:0] r, logic [2:0] b,
                              logic pc, logic [31:0] t, logic iss);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    func_i       <= f;
    rank_id_i    <= r;
    bank_id_i    <= b;
    posted_cas_i <= pc;
    now_i        <= t;
    issue_i      <= iss;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Waits until every expected gap has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] next_time(int step_max);
    cur_time += $urandom_range(step_max);
    return cur_time;
  endfunction

  function automatic logic issue_bit();
    return $urandom_range(9) != 0;
  endfunction

  // Field extremes, each command type, the no-op codes, the four-activate
  // window and timestamps half the time range away.
  task automatic directed_commands();
    send_command(FUNC_ACT,    2'd0, 3'd0, 1'b0, 32'd0,   1'b0);
    send_command(FUNC_ACT,    2'd3, 3'd7, 1'b1, 32'd100, 1'b1);
    send_command(FUNC_RD,     2'd3, 3'd7, 1'b1, 32'd101, 1'b1);
    send_command(FUNC_RDAP,   2'd3, 3'd7, 1'b1, 32'd102, 1'b1);
    send_command(FUNC_WR,     2'd3, 3'd7, 1'b1, 32'd103, 1'b1);
    send_command(FUNC_WRAP,   2'd3, 3'd7, 1'b1, 32'd104, 1'b1);
    send_command(FUNC_PRE,    2'd3, 3'd7, 1'b1, 32'd105, 1'b1);
    send_command(FUNC_REFALL, 2'd3, 3'd7, 1'b1, 32'd106, 1'b1);
    send_command(FUNC_RD,     2'd3, 3'd7, 1'b0, 32'd110, 1'b0);
    send_command(FUNC_NOP_FIRST, 2'd3, 3'd7, 1'b1, 32'd111, 1'b1);
    send_command(FUNC_NOP_MID,   2'd1, 3'd2, 1'b0, 32'd112, 1'b1);
    send_command(FUNC_NOP_LAST,  2'd3, 3'd7, 1'b1, 32'hFFFF_FFFF, 1'b1);
    for (int i = 0; i < 4; i++) send_command(FUNC_ACT, 2'd1, 3'(i), 1'b0, 32'(200 + i), 1'b1);
    send_command(FUNC_ACT,    2'd1, 3'd4, 1'b0, 32'd204, 1'b1);
    send_command(FUNC_ACT,    2'd1, 3'd5, 1'b0, 32'd260, 1'b0);
    send_command(FUNC_ACT,    2'd2, 3'd2, 1'b0, 32'h8000_0001, 1'b0);
    send_command(FUNC_REFALL, 2'd2, 3'd2, 1'b0, 32'h8000_0000, 1'b0);
    send_command(FUNC_WR,     2'd0, 3'd0, 1'b1, 32'hFFFF_FFFF, 1'b0);
  endtask

  // Mostly activate, column, precharge sequences on a few hot banks, with
  // some random commands mixed in.
  task automatic random_commands(int count);
    int          sent;
    int          step_max;
    logic [1:0]  r;
    logic [2:0]  b;
    logic [3:0]  f;
    logic [31:0] t;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(99) < 85) begin
        if ($urandom_range(99) < 70) begin
          r = 2'($urandom_range(1));
          b = 3'($urandom_range(3));
        end else begin
          r = 2'($urandom_range(3));
          b = 3'($urandom_range(7));
        end
        case ($urandom_range(2))
          0: step_max = 3;
          1: step_max = 24;
          default: step_max = 200;
        endcase
        send_command(FUNC_ACT, r, b, 1'($urandom_range(1)), next_time(step_max), issue_bit());
        sent++;
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(3))
            0: f = FUNC_RD;
            1: f = FUNC_RDAP;
            2: f = FUNC_WR;
            default: f = FUNC_WRAP;
          endcase
          send_command(f, r, b, 1'($urandom_range(1)), next_time(step_max), issue_bit());
          sent++;
        end
        send_command(FUNC_PRE, r, b, 1'($urandom_range(1)), next_time(step_max), issue_bit());
        sent++;
        if ($urandom_range(3) == 0) begin
          send_command(FUNC_REFALL, r, b, 1'($urandom_range(1)), next_time(step_max),
                       issue_bit());
          sent++;
        end
      end else begin
        if ($urandom_range(4) == 0) t = $urandom;
        else t = cur_time - 20 + $urandom_range(40);
        send_command(4'($urandom_range(15)), 2'($urandom_range(3)), 3'($urandom_range(7)),
                     1'($urandom_range(1)), t, 1'($urandom_range(1)));
        sent++;
      end
    end
  endtask

  // Main sequence: reset, then six segments with different timings and idling.
  initial begin
    sb = new();
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_T_RP;
    cfg_data_i   <= '0;
    in_valid_i   <= 1'b0;
    func_i       <= FUNC_ACT;
    rank_id_i    <= '0;
    bank_id_i    <= '0;
    posted_cas_i <= 1'b0;
    now_i        <= '0;
    issue_i      <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_time = 32'd300;
    for (int seg = 0; seg < 6; seg++) begin
      if (seg < 2) begin
        send_idle_pct = 7;
        recv_idle_pct = 55;
      end else if (seg < 4) begin
        send_idle_pct = 55;
        recv_idle_pct = 7;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      program_timings(seg);
      if (seg == 0) directed_commands();
      // Crossing the 32-bit wrap of the time counter.
      if (seg == 3) cur_time = 32'hFFFF_FC00;
      // Long result stall while commands keep coming, to back up the input.
      if (seg == 4) hold_req = 1'b1;
      random_commands(ITEMS_PER_SEG);
      wait_idle();
    end

    repeat (10) @(posedge clk_i);
    if (sb.pending() != 0) sb.report($sformatf("%0d expected gaps never returned", sb.pending()));
    if (sb.n_fail == 0) begin
      $display("** dram_timing_gap_checker: PASSED **");
    end else begin
      $display("** dram_timing_gap_checker: FAILED **");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2_000_000;
    $display("** dram_timing_gap_checker: FAILED **");
    $finish;
  end

endmodule
